// ===== rtl/core/ifn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifn_pkg: shared types and constants of the integrate-and-fire neuron
// field widths, command and status codes, sequencer states, synapse entry
// ----------------------------------------------------------------------------
package ifn_pkg;

	// default sizes
	localparam int MAX_SYNAPSES_DEF = 16;
	localparam int NUM_SOURCES_DEF  = 16;

	// field widths
	localparam int CMD_W      = 2;
	localparam int SRC_ID_W   = 4;
	localparam int WEIGHT_W   = 16;
	localparam int SVAL_W     = 9;
	localparam int POT_W      = 24;
	localparam int THR_W      = 16;
	localparam int ROLE_W     = 2;
	localparam int IMP_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;
	// value (10 bit signed, at most 1.0) times weight
	localparam int PROD_W     = 26;
	localparam int FRAC_W     = 8;

	localparam logic [SVAL_W-1:0]         ONE_Q8    = SVAL_W'(256);
	localparam logic signed [THR_W-1:0]   THR_RESET = THR_W'(256);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD  = 2'd0,
		CMD_TICK = 2'd1,
		CMD_SET  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_DONE     = 2'd0,
		STS_APPENDED = 2'd1,
		STS_MERGED   = 2'd2,
		STS_FULL     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 1'b0,
		REG_ROLE      = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_SCAN,
		S_ADD_WR,
		S_TICK_RUN,
		S_TICK_SUM,
		S_TICK_CMP,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [SRC_ID_W-1:0]        src;
		logic                       inv;
		logic signed [WEIGHT_W-1:0] weight;
	} syn_entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/integrate_fire_neuron.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integrate_fire_neuron: integrate-and-fire neuron with a synapse table
// sequencer around one multiply-accumulate and one synapse compare
// ----------------------------------------------------------------------------
// The block takes one item at a time and is not ready until its result is in
// the output register. Set source and the unused command go straight to the
// finish state, as does a tick right after firing. Add synapse scans the
// stored synapses, stops early when it merges, and then writes the merged or
// appended entry, or reports a full table without a write. A tick reads every
// stored synapse: the synapse
// memory hands out one entry per cycle on its single read port, and the tick
// pipeline (synapse read, source read, multiply, accumulate) then drains; a
// sum state adds and saturates, and a compare state compares. The finish
// state waits until the output register is free. There is no
// clearing pass after reset: source values carry one valid bit each, and only
// synapse entries below the fill count are ever used. Configuration writes are
// taken in any cycle and must come while the block is idle.
module integrate_fire_neuron
	#(
	parameter int MAX_SYNAPSES = ifn_pkg::MAX_SYNAPSES_DEF,
	parameter int NUM_SOURCES  = ifn_pkg::NUM_SOURCES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input items
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// source_id[3:0], inverted[4], weight[20:5], source_value[29:21], zero[31:30]
	input  wire logic [ifn_pkg::IN_DATA_W-1:0]   s_tdata,
	// command[1:0]
	input  wire logic [ifn_pkg::CMD_W-1:0]       s_tuser,
	// result items
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// fired[0], impulse[2:1], potential[26:3], status[28:27], zero[31:29]
	output logic      [ifn_pkg::OUT_DATA_W-1:0]  m_tdata,
	// configuration writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ifn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ifn_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import ifn_pkg::*;

	localparam int SYN_AW = (MAX_SYNAPSES > 1) ? $clog2(MAX_SYNAPSES) : 1;
	localparam int SRC_AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int CNT_W  = $clog2(MAX_SYNAPSES + 1);
	// sum of all products, then the floored sum and the membrane update
	localparam int ACC_W  = PROD_W + $clog2(MAX_SYNAPSES);
	localparam int SH_W   = ACC_W - FRAC_W;
	localparam int SUM_W  = ((SH_W > POT_W) ? SH_W : POT_W) + 1;
	localparam int SYN_W  = $bits(syn_entry_t);
	localparam logic signed [SUM_W-1:0] POT_HI = SUM_W'((2 ** (POT_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] POT_LO = -POT_HI - SUM_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SYNAPSES);

	// input item fields
	logic [SRC_ID_W-1:0]        in_sid;
	logic                       in_inv;
	logic signed [WEIGHT_W-1:0] in_wgt;
	logic [SVAL_W-1:0]          in_sval;
	logic                       in_accept;
	logic                       in_sid_ok;

	assign in_sid    = s_tdata[3:0];
	assign in_inv    = s_tdata[4];
	assign in_wgt    = s_tdata[20:5];
	assign in_sval   = s_tdata[29:21];
	assign in_accept = s_tvalid && s_tready;
	assign in_sid_ok = int'(in_sid) < NUM_SOURCES;

	// sequencer and control state
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic               vld_s1, vld_s2, vld_s3;
	logic [NUM_SOURCES-1:0] src_vld_q;
	logic signed [POT_W-1:0] membrane_q;
	logic               fired_flag_q;
	logic signed [THR_W-1:0] threshold_q;
	logic [ROLE_W-1:0]  role_q;
	logic               out_vld_q;

	// latched item and pipeline payload
	logic [SRC_ID_W-1:0]        sid_q;
	logic                       inv_q;
	logic signed [WEIGHT_W-1:0] wgt_q;
	logic [SYN_AW-1:0]          idx_s1;
	logic                       inv_s2;
	logic signed [WEIGHT_W-1:0] wgt_s2;
	logic                       ok_s2;
	logic signed [PROD_W-1:0]   prod_s3;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       res_fired_q;
	logic [IMP_W-1:0]           res_impulse_q;
	status_t                    res_status_q;
	logic [SYN_AW-1:0]          syn_wr_addr_q;
	syn_entry_t                 syn_wr_data_q;
	logic [OUT_DATA_W-1:0]      out_data_q;

	// combinational control
	logic       issue;
	logic       syn_we;
	logic       out_free;
	logic       match;
	logic       scan_end;
	logic       fire;
	logic       src_we;

	// memory ports
	logic [SYN_W-1:0]  syn_rdata;
	syn_entry_t        syn_rd;
	logic [SRC_AW-1:0] src_rd_addr;
	logic [SVAL_W-1:0] src_rdata;
	logic [SVAL_W-1:0] src_wdata;
	logic              src_ok_c;

	// arithmetic
	logic [SVAL_W-1:0]          val_c;
	logic [SVAL_W-1:0]          v_c;
	logic signed [SVAL_W:0]     v_ext;
	logic signed [PROD_W-1:0]   prod_c;
	logic signed [WEIGHT_W:0]   wsum_c;
	logic signed [WEIGHT_W-1:0] wsat_c;
	logic signed [SUM_W-1:0]    pot_sum_c;
	logic signed [POT_W-1:0]    pot_sat_c;

	assign syn_rd = syn_entry_t'(syn_rdata);

	// synapse table: source, inversion, weight
	ifn_ram #(
		.WIDTH(SYN_W),
		.DEPTH(MAX_SYNAPSES)
	) u_syn_ram (
		.clk    (clk),
		.wr_en  (syn_we),
		.wr_addr(syn_wr_addr_q),
		.wr_data(syn_wr_data_q),
		.rd_addr(rd_cnt_q[SYN_AW-1:0]),
		.rd_data(syn_rdata)
	);

	// presynaptic values, read at the source of the synapse just fetched
	assign src_rd_addr = SRC_AW'(syn_rd.src);
	assign src_ok_c    = (int'(syn_rd.src) < NUM_SOURCES) && src_vld_q[src_rd_addr];
	assign src_we      = in_accept && (s_tuser == CMD_SET) && in_sid_ok;
	// values above 1.0 are stored as 1.0
	assign src_wdata   = (in_sval > ONE_Q8) ? ONE_Q8 : in_sval;

	ifn_ram #(
		.WIDTH(SVAL_W),
		.DEPTH(NUM_SOURCES)
	) u_src_ram (
		.clk    (clk),
		.wr_en  (src_we),
		.wr_addr(SRC_AW'(in_sid)),
		.wr_data(src_wdata),
		.rd_addr(src_rd_addr),
		.rd_data(src_rdata)
	);

	// tick datapath: never-written or out-of-range sources read as zero
	assign val_c  = ok_s2 ? src_rdata : '0;
	assign v_c    = inv_s2 ? (ONE_Q8 - val_c) : val_c;
	assign v_ext  = signed'({1'b0, v_c});
	assign prod_c = PROD_W'(v_ext) * PROD_W'(wgt_s2);

	// floor of the sum to q.8 is an arithmetic shift
	assign pot_sum_c = SUM_W'(membrane_q) + SUM_W'(acc_q >>> FRAC_W);
	always_comb begin
		if (pot_sum_c > POT_HI) begin
			pot_sat_c = POT_HI[POT_W-1:0];
		end else if (pot_sum_c < POT_LO) begin
			pot_sat_c = POT_LO[POT_W-1:0];
		end else begin
			pot_sat_c = pot_sum_c[POT_W-1:0];
		end
	end

	// merge: saturating 16-bit weight sum
	assign wsum_c = (WEIGHT_W + 1)'(syn_rd.weight) + (WEIGHT_W + 1)'(wgt_q);
	always_comb begin
		if (wsum_c[WEIGHT_W] != wsum_c[WEIGHT_W-1]) begin
			wsat_c = wsum_c[WEIGHT_W] ? {1'b1, {(WEIGHT_W - 1){1'b0}}}
			                          : {1'b0, {(WEIGHT_W - 1){1'b1}}};
		end else begin
			wsat_c = wsum_c[WEIGHT_W-1:0];
		end
	end

	assign match    = (syn_rd.src == sid_q) && (syn_rd.inv == inv_q);
	assign scan_end = !vld_s1 && (rd_cnt_q == cnt_q);
	assign fire     = membrane_q >= POT_W'(threshold_q);
	assign out_free = !out_vld_q || m_tready;

	// next state and sequencer outputs
	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		syn_we  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						CMD_ADD:  state_d = S_ADD_SCAN;
						CMD_TICK: state_d = fired_flag_q ? S_FINISH : S_TICK_RUN;
						default:  state_d = S_FINISH;
					endcase
				end
			end
			S_ADD_SCAN: begin
				// stop fetching on the first hit
				issue = (rd_cnt_q < cnt_q) && !(vld_s1 && match);
				if (vld_s1 && match) begin
					state_d = S_ADD_WR;
				end else if (scan_end) begin
					state_d = (cnt_q == CNT_FULL) ? S_FINISH : S_ADD_WR;
				end
			end
			S_ADD_WR: begin
				syn_we  = 1'b1;
				state_d = S_FINISH;
			end
			S_TICK_RUN: begin
				issue = rd_cnt_q < cnt_q;
				if (!issue && !vld_s1 && !vld_s2 && !vld_s3) begin
					state_d = S_TICK_SUM;
				end
			end
			S_TICK_SUM: state_d = S_TICK_CMP;
			S_TICK_CMP: state_d = S_FINISH;
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_data_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			rd_cnt_q     <= '0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			src_vld_q    <= '0;
			membrane_q   <= '0;
			fired_flag_q <= 1'b0;
			threshold_q  <= THR_RESET;
			role_q       <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			// only a tick feeds the multiply-accumulate
			vld_s2  <= vld_s1 && (state_q == S_TICK_RUN);
			vld_s3  <= vld_s2;

			if (in_accept) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end

			// append
			if ((state_q == S_ADD_SCAN) && !(vld_s1 && match) && scan_end
			    && (cnt_q != CNT_FULL)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if (src_we) begin
				src_vld_q[SRC_AW'(in_sid)] <= 1'b1;
			end

			// the tick after firing only clears the flag
			if (in_accept && (s_tuser == CMD_TICK) && fired_flag_q) begin
				fired_flag_q <= 1'b0;
			end

			if (state_q == S_TICK_SUM) begin
				membrane_q <= pot_sat_c;
			end
			if ((state_q == S_TICK_CMP) && fire) begin
				membrane_q   <= '0;
				fired_flag_q <= 1'b1;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
					REG_ROLE:      role_q      <= cfg_data[ROLE_W-1:0];
					default:       ;
				endcase
			end

			if ((state_q == S_FINISH) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1  <= rd_cnt_q[SYN_AW-1:0];
		inv_s2  <= syn_rd.inv;
		wgt_s2  <= syn_rd.weight;
		ok_s2   <= src_ok_c;
		prod_s3 <= prod_c;
		if (vld_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end

		if (in_accept) begin
			sid_q         <= in_sid;
			inv_q         <= in_inv;
			wgt_q         <= in_wgt;
			acc_q         <= '0;
			res_fired_q   <= 1'b0;
			res_impulse_q <= '0;
			res_status_q  <= STS_DONE;
		end

		if (state_q == S_ADD_SCAN) begin
			if (vld_s1 && match) begin
				syn_wr_addr_q <= idx_s1;
				syn_wr_data_q <= '{src: syn_rd.src, inv: syn_rd.inv, weight: wsat_c};
				res_status_q  <= STS_MERGED;
			end else if (scan_end) begin
				if (cnt_q == CNT_FULL) begin
					res_status_q <= STS_FULL;
				end else begin
					syn_wr_addr_q <= cnt_q[SYN_AW-1:0];
					syn_wr_data_q <= '{src: sid_q, inv: inv_q, weight: wgt_q};
					res_status_q  <= STS_APPENDED;
				end
			end
		end

		if ((state_q == S_TICK_CMP) && fire) begin
			res_fired_q   <= 1'b1;
			res_impulse_q <= role_q;
		end

		if ((state_q == S_FINISH) && out_free) begin
			out_data_q <= {3'b000, res_status_q, membrane_q, res_impulse_q, res_fired_q};
		end
	end

	// the fill count never passes the table size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("synapse count beyond table size");

	// no fetch or product in flight while a new item may enter
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(vld_s1 || vld_s2 || vld_s3))
		else $error("pipeline busy while ready");

	// the fired flag is set only by a threshold compare
	a_fire_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fired_flag_q) |-> $past(state_q) == S_TICK_CMP)
		else $error("fired flag set outside compare");

	// a firing result reports a reset potential
	a_fire_pot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[26:3] == '0))
		else $error("fired result with nonzero potential");

	// an append write comes with a nonzero fill count
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD_WR && res_status_q == STS_APPENDED) |-> cnt_q != '0)
		else $error("append without count increment");

endmodule
`default_nettype wire

// ===== rtl/core/ifn_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifn_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ifn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire
